[rtl/four_motor_health_checker_top_defines.svh]
// Assertion macros used by the checker top RTL.
// Each use takes a label, an antecedent, a consequent and a message string.
`ifndef FOUR_MOTOR_HEALTH_CHECKER_TOP_DEFINES_SVH
`define FOUR_MOTOR_HEALTH_CHECKER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FMHC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FMHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fmhc_pkg.sv]
`timescale 1ns / 1ps

package fmhc_pkg;

   // fixed field widths
   localparam int AVG_W  = 24;   // Q16.8 running average
   localparam int SUM_W  = 26;   // sum of four averages
   localparam int LIM_W  = 9;    // Q1.8 ratio limit
   localparam int CFG_W  = 16;   // tick registers and csr data
   localparam int CODE_W = 3;
   localparam int MAG_W  = 16;   // saturated magnitude
   localparam int RSP_W  = 24;   // packed result tdata
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [CFG_W-1:0] TEST_TICKS_RST   = 16'd250;
   localparam logic [CFG_W-1:0] IGNORE_TICKS_RST = 16'd50;
   localparam logic [LIM_W-1:0] ENC_LIMIT_RST    = 9'd128;
   localparam logic [LIM_W-1:0] AMP_LIMIT_RST    = 9'd128;

   // wheel grades
   localparam logic [CODE_W-1:0] CODE_NONE   = 3'd0;
   localparam logic [CODE_W-1:0] CODE_GOOD   = 3'd1;
   localparam logic [CODE_W-1:0] CODE_AMP    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_ENC    = 3'd3;
   localparam logic [CODE_W-1:0] CODE_NO_AMP = 3'd4;
   localparam logic [CODE_W-1:0] CODE_NO_ENC = 3'd5;

   typedef enum logic [1:0] {
      PHASE_STOP  = 2'd0,
      PHASE_DRIVE = 2'd1,
      PHASE_STEER = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      REPORT_NONE  = 2'd0,
      REPORT_DRIVE = 2'd1,
      REPORT_STEER = 2'd2
   } report_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEST_TICKS   = 2'd0,
      CSR_IGNORE_TICKS = 2'd1,
      CSR_ENC_LIMIT    = 2'd2,
      CSR_AMP_LIMIT    = 2'd3
   } csr_index_type;

   // per-item control that travels down the pipeline
   typedef struct packed {
      logic       test_active;
      phase_type  phase;
      logic       drive_power;
      logic       steer_power;
      report_type report;
   } ctl_type;

endpackage

[rtl/four_motor_health_checker_top.sv]
`timescale 1ns / 1ps

// Four-motor self-test checker. Each req item is one control tick carrying the
// enable and the four current and four velocity samples; each tick returns
// exactly one rsp item with phase, power commands and, once past the ignore
// window, a grade per wheel. The block takes one item per clock cycle while
// rsp_tready does not hold the pipeline back; the running averages and phase
// counter update in the cycle the item is accepted, so consecutive ticks
// chain without a gap. A result passes the stage A register (accept/average
// update), the stage B register (four-wheel sums), then the grading multiplies
// into the output register. Four lanes do the per-wheel work in parallel.
// Configuration writes should be made while no item is in flight.
module four_motor_health_checker_top
   import fmhc_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int TICK_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata, low bit up: enable, amp_fl, amp_fr, amp_rl, amp_rr,
   //   vel_fl, vel_fr, vel_rl, vel_rr, zero fill
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [((1+8*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // rsp_tdata, low bit up: test_active, phase_now[1:0], drive_power,
   //   steer_power, code_fl, code_fr, code_rl, code_rr, zero fill
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,
   // rsp_tuser: report_kind
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CFG_W-1:0]              csr_data
);

`include "four_motor_health_checker_top_defines.svh"

   localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

   // configuration
   logic [CFG_W-1:0] test_ticks_ff;
   logic [CFG_W-1:0] ignore_ticks_ff;
   logic [LIM_W-1:0] enc_limit_ff;
   logic [LIM_W-1:0] amp_limit_ff;

   // test state
   logic                 running_ff;
   logic                 running_in;
   phase_type            phase_ff;
   phase_type            phase_in;
   phase_type            act_phase;
   logic [TICK_BITS-1:0] cnt_ff;
   logic [TICK_BITS-1:0] cnt_in;
   logic [TICK_BITS-1:0] cnt_act;
   logic [AVG_W-1:0]     drive_amp_ff [4];
   logic [AVG_W-1:0]     drive_vel_ff [4];
   logic [AVG_W-1:0]     steer_amp_ff [4];
   logic [AVG_W-1:0]     steer_vel_ff [4];

   // tick decode
   logic       accept;
   logic       en;
   logic       clr;
   logic       run;
   logic       live;
   logic       smp;
   ctl_type    ctl_in;
   logic [CMP_W-1:0] cnt_x;

   // lane signals
   logic signed [SAMPLE_BITS-1:0] amp_s [4];
   logic signed [SAMPLE_BITS-1:0] vel_s [4];
   logic [AVG_W-1:0] amp_old [4];
   logic [AVG_W-1:0] vel_old [4];
   logic [AVG_W-1:0] amp_new [4];
   logic [AVG_W-1:0] vel_new [4];

   // pipeline stages
   logic             a_v_ff;
   ctl_type          a_ctl_ff;
   logic [AVG_W-1:0] a_amp_ff [4];
   logic [AVG_W-1:0] a_vel_ff [4];
   logic             b_v_ff;
   ctl_type          b_ctl_ff;
   logic [AVG_W-1:0] b_amp_ff [4];
   logic [AVG_W-1:0] b_vel_ff [4];
   logic [SUM_W-1:0] b_amp_sum_ff;
   logic [SUM_W-1:0] b_vel_sum_ff;
   logic [SUM_W-1:0] amp_sum;
   logic [SUM_W-1:0] vel_sum;
   logic              c_v_ff;
   ctl_type           c_ctl_ff;
   logic [CODE_W-1:0] c_code_ff [4];
   logic [CODE_W-1:0] lane_code [4];
   logic a_ok;
   logic b_ok;
   logic c_ok;

   // handshakes: each stage loads when empty or when it drains
   assign c_ok       = !c_v_ff || rsp_tready;
   assign b_ok       = !b_v_ff || c_ok;
   assign a_ok       = !a_v_ff || b_ok;
   assign req_tready = a_ok;
   assign accept     = req_tvalid && a_ok;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         test_ticks_ff   <= TEST_TICKS_RST;
         ignore_ticks_ff <= IGNORE_TICKS_RST;
         enc_limit_ff    <= ENC_LIMIT_RST;
         amp_limit_ff    <= AMP_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEST_TICKS:   test_ticks_ff   <= csr_data;
            CSR_IGNORE_TICKS: ignore_ticks_ff <= csr_data;
            CSR_ENC_LIMIT:    enc_limit_ff    <= csr_data[LIM_W-1:0];
            CSR_AMP_LIMIT:    amp_limit_ff    <= csr_data[LIM_W-1:0];
         endcase
      end
   end

   // unpack samples
   assign en = req_tdata[0];
   for (genvar i = 0; i < 4; i++) begin : g_unpack
      assign amp_s[i] = req_tdata[1 + i*SAMPLE_BITS +: SAMPLE_BITS];
      assign vel_s[i] = req_tdata[1 + (4+i)*SAMPLE_BITS +: SAMPLE_BITS];
   end

   // enable edges: falling clears, rising starts the drive phase
   assign clr       = running_ff && !en;
   assign act_phase = clr ? PHASE_STOP
                    : (!running_ff && en) ? PHASE_DRIVE : phase_ff;
   assign cnt_act   = clr ? '0 : cnt_ff;
   assign cnt_x     = CMP_W'(cnt_act);
   assign run       = en && (act_phase == PHASE_DRIVE || act_phase == PHASE_STEER);
   assign live      = run && (cnt_x < CMP_W'(test_ticks_ff));
   assign smp       = live && (cnt_x > CMP_W'(ignore_ticks_ff));

   // next state
   always_comb begin
      running_in = en;
      phase_in   = act_phase;
      cnt_in     = cnt_act;
      if (live) begin
         if (cnt_act != {TICK_BITS{1'b1}}) begin
            cnt_in = cnt_act + 1'b1;
         end
      end else if (run) begin
         cnt_in   = '0;
         phase_in = (act_phase == PHASE_DRIVE) ? PHASE_STEER : PHASE_STOP;
      end
   end

   // per-tick outputs
   always_comb begin
      ctl_in.test_active = en;
      ctl_in.phase       = phase_in;
      ctl_in.drive_power = live && (act_phase == PHASE_DRIVE);
      ctl_in.steer_power = live && (act_phase == PHASE_STEER);
      if (!smp) begin
         ctl_in.report = REPORT_NONE;
      end else if (act_phase == PHASE_DRIVE) begin
         ctl_in.report = REPORT_DRIVE;
      end else begin
         ctl_in.report = REPORT_STEER;
      end
   end

   // averaging lanes
   for (genvar i = 0; i < 4; i++) begin : g_upd
      assign amp_old[i] = (act_phase == PHASE_DRIVE) ? drive_amp_ff[i] : steer_amp_ff[i];
      assign vel_old[i] = (act_phase == PHASE_DRIVE) ? drive_vel_ff[i] : steer_vel_ff[i];
      fmhc_upd #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_upd (
         .amp_sample (amp_s[i]),
         .vel_sample (vel_s[i]),
         .amp_old    (amp_old[i]),
         .vel_old    (vel_old[i]),
         .amp_new    (amp_new[i]),
         .vel_new    (vel_new[i])
      );
   end

   // test state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         phase_ff   <= PHASE_STOP;
         cnt_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            drive_amp_ff[i] <= '0;
            drive_vel_ff[i] <= '0;
            steer_amp_ff[i] <= '0;
            steer_vel_ff[i] <= '0;
         end
      end else if (accept) begin
         running_ff <= running_in;
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         for (int i = 0; i < 4; i++) begin
            if (clr) begin
               drive_amp_ff[i] <= '0;
               drive_vel_ff[i] <= '0;
               steer_amp_ff[i] <= '0;
               steer_vel_ff[i] <= '0;
            end else if (smp && act_phase == PHASE_DRIVE) begin
               drive_amp_ff[i] <= amp_new[i];
               drive_vel_ff[i] <= vel_new[i];
            end else if (smp) begin
               steer_amp_ff[i] <= amp_new[i];
               steer_vel_ff[i] <= vel_new[i];
            end
         end
      end
   end

   // stage A: control and fresh averages
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_ok) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ctl_ff <= ctl_in;
         for (int i = 0; i < 4; i++) begin
            a_amp_ff[i] <= amp_new[i];
            a_vel_ff[i] <= vel_new[i];
         end
      end
   end

   // stage B: four-wheel sums
   fmhc_sum u_sum (
      .amp_avg (a_amp_ff),
      .vel_avg (a_vel_ff),
      .amp_sum (amp_sum),
      .vel_sum (vel_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_ok) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ok && a_v_ff) begin
         b_ctl_ff     <= a_ctl_ff;
         b_amp_sum_ff <= amp_sum;
         b_vel_sum_ff <= vel_sum;
         for (int i = 0; i < 4; i++) begin
            b_amp_ff[i] <= a_amp_ff[i];
            b_vel_ff[i] <= a_vel_ff[i];
         end
      end
   end

   // stage C: grading lanes into the output register
   for (genvar i = 0; i < 4; i++) begin : g_grade
      fmhc_grade u_grade (
         .amp_avg   (b_amp_ff[i]),
         .vel_avg   (b_vel_ff[i]),
         .amp_sum   (b_amp_sum_ff),
         .vel_sum   (b_vel_sum_ff),
         .amp_limit (amp_limit_ff),
         .enc_limit (enc_limit_ff),
         .code      (lane_code[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (c_ok) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ok && b_v_ff) begin
         c_ctl_ff <= b_ctl_ff;
         for (int i = 0; i < 4; i++) begin
            c_code_ff[i] <= (b_ctl_ff.report == REPORT_NONE) ? CODE_NONE : lane_code[i];
         end
      end
   end

   // result packing
   assign rsp_tvalid = c_v_ff;
   assign rsp_tuser  = c_ctl_ff.report;
   assign rsp_tdata  = {7'd0, c_code_ff[3], c_code_ff[2], c_code_ff[1], c_code_ff[0],
                        c_ctl_ff.steer_power, c_ctl_ff.drive_power,
                        c_ctl_ff.phase, c_ctl_ff.test_active};

   // checks
   `FMHC_ASSERT_SAME(a_codes_zero_no_report,
      c_v_ff && c_ctl_ff.report == REPORT_NONE,
      c_code_ff[0] == CODE_NONE && c_code_ff[1] == CODE_NONE &&
      c_code_ff[2] == CODE_NONE && c_code_ff[3] == CODE_NONE,
      "grades present without a report")
   `FMHC_ASSERT_SAME(a_power_exclusive, c_v_ff,
      !(c_ctl_ff.drive_power && c_ctl_ff.steer_power),
      "drive and steer power both commanded")
   `FMHC_ASSERT_SAME(a_report_has_power, c_v_ff && c_ctl_ff.report != REPORT_NONE,
      c_ctl_ff.drive_power || c_ctl_ff.steer_power,
      "report on a tick without power")
   `FMHC_ASSERT_NEXT(a_disable_clears, accept && !en,
      phase_ff == PHASE_STOP && cnt_ff == '0 && !running_ff,
      "disabled tick did not clear the test state")

endmodule

[rtl/fmhc_upd.sv]
`timescale 1ns / 1ps

// One wheel lane: folds the current and velocity samples into their averages.
module fmhc_upd
   import fmhc_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic signed [SAMPLE_BITS-1:0] amp_sample,
   input  logic signed [SAMPLE_BITS-1:0] vel_sample,
   input  logic        [AVG_W-1:0]       amp_old,
   input  logic        [AVG_W-1:0]       vel_old,
   output logic        [AVG_W-1:0]       amp_new,
   output logic        [AVG_W-1:0]       vel_new
);

   logic [MAG_W-1:0] amp_mag;
   logic [MAG_W-1:0] vel_mag;

   // two's complement magnitude, saturated to 16 bits
   function automatic logic [MAG_W-1:0] sat_mag(input logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] m;
      logic [32:0]            w;
      m = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
      w = 33'(m);
      return (|w[32:MAG_W]) ? {MAG_W{1'b1}} : w[MAG_W-1:0];
   endfunction

   // avg = (avg + (|x| << 8)) >> 1
   function automatic logic [AVG_W-1:0] fold(input logic [AVG_W-1:0] avg,
                                              input logic [MAG_W-1:0] mag);
      logic [AVG_W:0] sum;
      sum = {1'b0, avg} + {1'b0, mag, 8'd0};
      return sum[AVG_W:1];
   endfunction

   assign amp_mag = sat_mag(amp_sample);
   assign vel_mag = sat_mag(vel_sample);
   assign amp_new = fold(amp_old, amp_mag);
   assign vel_new = fold(vel_old, vel_mag);

endmodule

[rtl/fmhc_sum.sv]
`timescale 1ns / 1ps

// Merge stage: four-wheel sums of current and velocity averages.
module fmhc_sum
   import fmhc_pkg::*;
(
   input  logic [AVG_W-1:0] amp_avg [4],
   input  logic [AVG_W-1:0] vel_avg [4],
   output logic [SUM_W-1:0] amp_sum,
   output logic [SUM_W-1:0] vel_sum
);

   assign amp_sum = (SUM_W'(amp_avg[0]) + SUM_W'(amp_avg[1]))
                  + (SUM_W'(amp_avg[2]) + SUM_W'(amp_avg[3]));
   assign vel_sum = (SUM_W'(vel_avg[0]) + SUM_W'(vel_avg[1]))
                  + (SUM_W'(vel_avg[2]) + SUM_W'(vel_avg[3]));

endmodule

[rtl/fmhc_grade.sv]
`timescale 1ns / 1ps

// One wheel lane: grades a wheel against the four-wheel mean.
// Low means v * 1024 < limit * sum.
module fmhc_grade
   import fmhc_pkg::*;
(
   input  logic [AVG_W-1:0]  amp_avg,
   input  logic [AVG_W-1:0]  vel_avg,
   input  logic [SUM_W-1:0]  amp_sum,
   input  logic [SUM_W-1:0]  vel_sum,
   input  logic [LIM_W-1:0]  amp_limit,
   input  logic [LIM_W-1:0]  enc_limit,
   output logic [CODE_W-1:0] code
);

   localparam int PROD_W = LIM_W + SUM_W;

   logic [PROD_W-1:0] amp_thr;
   logic [PROD_W-1:0] vel_thr;
   logic              amp_low;
   logic              enc_low;

   assign amp_thr = PROD_W'(amp_limit) * PROD_W'(amp_sum);
   assign vel_thr = PROD_W'(enc_limit) * PROD_W'(vel_sum);
   assign amp_low = PROD_W'({amp_avg, 10'd0}) < amp_thr;
   assign enc_low = PROD_W'({vel_avg, 10'd0}) < vel_thr;

   // missing signals first, then current low, then encoder low
   always_comb begin
      priority if (amp_avg == '0) begin
         code = CODE_NO_AMP;
      end else if (vel_avg == '0) begin
         code = CODE_NO_ENC;
      end else if (amp_low) begin
         code = CODE_AMP;
      end else if (enc_low) begin
         code = CODE_ENC;
      end else begin
         code = CODE_GOOD;
      end
   end

endmodule
